/* hdl/apa102_strip_frame_engine_unit_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the strip frame engine
// Shorthands for clocked implications, disabled while the active-low reset is low.
// ----------------------------------------------------------------------------
`ifndef APA102_STRIP_FRAME_ENGINE_UNIT_ASSERT_SVH
`define APA102_STRIP_FRAME_ENGINE_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define ASFE_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASFE_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hdl/asfe_pkg.sv */
// ----------------------------------------------------------------------------
// asfe_pkg
// Shared types, codes and helper functions of the strip frame engine.
// ----------------------------------------------------------------------------
package asfe_pkg;

  localparam int MAX_LEDS_DEF = 32;
  localparam int FIELD_IDX_W  = 6;

  localparam logic [2:0] OP_SET_ALL     = 3'd0;
  localparam logic [2:0] OP_SET_COLOUR  = 3'd1;
  localparam logic [2:0] OP_SET_LEVEL   = 3'd2;
  localparam logic [2:0] OP_CLEAR       = 3'd3;
  localparam logic [2:0] OP_LOAD_GAMMA  = 3'd4;
  localparam logic [2:0] OP_SHOW        = 3'd5;
  localparam logic [2:0] OP_READ        = 3'd6;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FIRST = 2'd1;
  localparam logic [1:0] ST_LAST  = 2'd2;
  localparam logic [1:0] ST_LEVEL = 2'd3;

  localparam logic [1:0] CFG_LED_COUNT = 2'd0;
  localparam logic [1:0] CFG_GAMMA_EN  = 2'd1;
  localparam logic [1:0] CFG_VBR_EN    = 2'd2;

  localparam logic [2:0] WORD_BYTES = 3'd4;
  localparam logic [5:0] LEVEL_MAX  = 6'd31;

  typedef struct packed {
    logic [4:0] level;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  localparam pix_t PIX_RESET = '{level: 5'h1F, blue: 8'h00, green: 8'h00, red: 8'h00};

  typedef struct packed {
    logic rd;
    logic wr;
  } pix_cmd_t;

  typedef struct packed {
    logic       rd;
    logic       wr;
    logic [7:0] addr;
    logic [7:0] wdata;
  } gam_req_t;

  // floor(31 * max(r, g, b) / 255), with x / 255 done as ((x + 1) * 257) >> 16.
  function automatic logic [4:0] vbr_level(input pix_t p);
    logic [7:0]  m;
    logic [12:0] y;
    logic [20:0] t;
    m = p.red;
    if (p.green > m) begin
      m = p.green;
    end
    if (p.blue > m) begin
      m = p.blue;
    end
    y = ({5'd0, m} << 5) - {5'd0, m} + 13'd1;
    t = ({8'd0, y} << 8) + {8'd0, y};
    return t[20:16];
  endfunction

  function automatic logic [2:0] footer_bytes(input logic [5:0] cnt);
    logic [6:0] s;
    s = {1'b0, cnt} + 7'd15;
    return s[6:4];
  endfunction

  function automatic logic [31:0] footer_word(input logic [2:0] nbytes);
    logic [31:0] w;
    w = '0;
    for (int k = 0; k < 4; k++) begin
      if (3'(k) < nbytes) begin
        w[31 - 8 * k -: 8] = 8'hFF;
      end
    end
    return w;
  endfunction

endpackage

/* hdl/asfe_pix_mem.sv */
// ----------------------------------------------------------------------------
// asfe_pix_mem
// Pixel store: one synchronous memory with registered read data and a valid
// bit per LED; an entry that is not valid reads as full brightness and black.
// ----------------------------------------------------------------------------
module asfe_pix_mem #(
  parameter int MAX_LEDS = asfe_pkg::MAX_LEDS_DEF,
  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
  localparam int CNT_W = $clog2(MAX_LEDS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  asfe_pkg::pix_cmd_t cmd,
  input  logic [IDX_W-1:0]   addr,
  input  asfe_pkg::pix_t     wdata,
  input  logic               clr_en,
  input  logic [CNT_W-1:0]   clr_lo,
  input  logic [CNT_W-1:0]   clr_hi,
  output asfe_pkg::pix_t     rdata
);
  import asfe_pkg::*;

  pix_t              mem [MAX_LEDS];
  logic [MAX_LEDS-1:0] valid_r;
  pix_t              rdata_r;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      mem[addr] <= wdata;
    end
    if (cmd.rd) begin
      rdata_r <= valid_r[addr] ? mem[addr] : PIX_RESET;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else begin
      for (int i = 0; i < MAX_LEDS; i++) begin
        if (clr_en && (CNT_W'(i) >= clr_lo) && (CNT_W'(i) < clr_hi)) begin
          valid_r[i] <= 1'b0;
        end
      end
      if (cmd.wr) begin
        valid_r[addr] <= 1'b1;
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/asfe_gam_mem.sv */
// ----------------------------------------------------------------------------
// asfe_gam_mem
// Gamma table: 256 by 8 synchronous memory with registered read data and a
// valid bit per entry; an entry never loaded reads as its own index.
// ----------------------------------------------------------------------------
module asfe_gam_mem (
  input  logic               clk,
  input  logic               rst_n,
  input  asfe_pkg::gam_req_t req,
  output logic [7:0]         rdata
);
  import asfe_pkg::*;

  logic [7:0]   mem [256];
  logic [255:0] valid_r;
  logic [7:0]   rdata_r;

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.addr] <= req.wdata;
    end
    if (req.rd) begin
      rdata_r <= valid_r[req.addr] ? mem[req.addr] : req.addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (req.wr) begin
      valid_r[req.addr] <= 1'b1;
    end
  end

  assign rdata = rdata_r;

endmodule

/* hdl/asfe_seq.sv */
// ----------------------------------------------------------------------------
// asfe_seq
// Operation sequencer: decodes one item, walks the pixel store for range
// writes and show, drives gamma lookups and holds the result register.
// ----------------------------------------------------------------------------
module asfe_seq #(
  parameter int MAX_LEDS = asfe_pkg::MAX_LEDS_DEF,
  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1,
  localparam int CNT_W = $clog2(MAX_LEDS + 1)
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [63:0]        in_tdata,
  input  logic [2:0]         in_tuser,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [63:0]        out_tdata,
  output logic [1:0]         out_tuser,
  output logic               out_tlast,
  input  logic [CNT_W-1:0]   count,
  input  logic               gamma_en,
  input  logic               vbr_en,
  output asfe_pkg::pix_cmd_t pix_cmd,
  output logic [IDX_W-1:0]   pix_addr,
  output asfe_pkg::pix_t     pix_wdata,
  input  asfe_pkg::pix_t     pix_rdata,
  output asfe_pkg::gam_req_t gam_req,
  input  logic [7:0]         gam_rdata
);
  import asfe_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DECODE, S_WR_RD, S_WR_WB, S_RESULT,
    S_SH_HDR, S_SH_RD, S_SH_PIX, S_SH_G1, S_SH_G2, S_SH_G3, S_SH_WORD, S_SH_FTR
  } state_t;

  state_t     st_r;
  logic [2:0] op_r;
  logic [5:0] first_r, last_r, level_r;
  logic [7:0] red_r, green_r, blue_r, slot_r, entry_r;
  logic [1:0] status_r;
  logic       read_ok_r;
  logic [IDX_W-1:0] idx_r;
  pix_t       px_r;
  logic [4:0] lv_r;
  logic [7:0] gb_r, gg_r, gr_r;

  logic        out_tvalid_r, out_last_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_word_r;
  logic [2:0]  out_bytes_r;
  pix_t        out_pix_r;

  logic [5:0]  count6;
  logic        first_ok, idx_at_last, idx_at_end, slot_free;
  logic [1:0]  status_nxt;
  logic        push_req, push_last;
  logic [1:0]  push_status;
  logic [31:0] push_word;
  logic [2:0]  push_bytes, fbytes;
  pix_t        push_pix;

  assign count6      = FIELD_IDX_W'(count);
  assign first_ok    = first_r < count6;
  assign idx_at_last = FIELD_IDX_W'(idx_r) == last_r;
  assign idx_at_end  = (CNT_W'(idx_r) + CNT_W'(1)) == count;
  assign slot_free   = !out_tvalid_r || out_tready;
  assign fbytes      = footer_bytes(count6);

  always_comb begin
    status_nxt = ST_OK;
    if (!first_ok) begin
      status_nxt = ST_FIRST;
    end else if ((op_r != OP_READ) && ((last_r < first_r) || (last_r >= count6))) begin
      status_nxt = ST_LAST;
    end else if (((op_r == OP_SET_ALL) || (op_r == OP_SET_LEVEL)) && (level_r > LEVEL_MAX)) begin
      status_nxt = ST_LEVEL;
    end
  end

  always_comb begin
    pix_cmd   = '0;
    pix_addr  = idx_r;
    pix_wdata = PIX_RESET;
    gam_req   = '0;
    case (st_r)
      S_DECODE: begin
        if ((op_r == OP_READ) && first_ok) begin
          pix_cmd.rd = 1'b1;
          pix_addr   = first_r[IDX_W-1:0];
        end
        if (op_r == OP_LOAD_GAMMA) begin
          gam_req.wr    = 1'b1;
          gam_req.addr  = slot_r;
          gam_req.wdata = entry_r;
        end
      end
      S_WR_RD: begin
        pix_cmd.rd = 1'b1;
      end
      S_WR_WB: begin
        pix_cmd.wr = 1'b1;
        pix_wdata  = pix_rdata;
        if (op_r == OP_CLEAR) begin
          pix_wdata = PIX_RESET;
        end else begin
          if (op_r != OP_SET_LEVEL) begin
            pix_wdata.red   = red_r;
            pix_wdata.green = green_r;
            pix_wdata.blue  = blue_r;
          end
          if (op_r != OP_SET_COLOUR) begin
            pix_wdata.level = level_r[4:0];
          end
        end
      end
      S_SH_RD: begin
        pix_cmd.rd = 1'b1;
      end
      S_SH_PIX: begin
        gam_req.rd   = gamma_en;
        gam_req.addr = pix_rdata.blue;
      end
      S_SH_G1: begin
        gam_req.rd   = 1'b1;
        gam_req.addr = px_r.green;
      end
      S_SH_G2: begin
        gam_req.rd   = 1'b1;
        gam_req.addr = px_r.red;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    push_req    = 1'b0;
    push_status = ST_OK;
    push_word   = '0;
    push_bytes  = '0;
    push_last   = 1'b0;
    push_pix    = '0;
    case (st_r)
      S_RESULT: begin
        push_req    = 1'b1;
        push_status = status_r;
        push_last   = 1'b1;
        if (read_ok_r) begin
          push_pix = pix_rdata;
        end
      end
      S_SH_HDR: begin
        push_req   = 1'b1;
        push_bytes = WORD_BYTES;
      end
      S_SH_WORD: begin
        push_req   = 1'b1;
        push_bytes = WORD_BYTES;
        if (gamma_en) begin
          push_word = {3'b111, lv_r, gb_r, gg_r, gr_r};
        end else begin
          push_word = {3'b111, lv_r, px_r.blue, px_r.green, px_r.red};
        end
      end
      S_SH_FTR: begin
        push_req   = 1'b1;
        push_bytes = fbytes;
        push_word  = footer_word(fbytes);
        push_last  = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r         <= S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      if (push_req && slot_free) begin
        out_tvalid_r <= 1'b1;
        out_status_r <= push_status;
        out_word_r   <= push_word;
        out_bytes_r  <= push_bytes;
        out_last_r   <= push_last;
        out_pix_r    <= push_pix;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      case (st_r)
        S_IDLE: begin
          if (in_tvalid) begin
            op_r    <= in_tuser;
            first_r <= in_tdata[5:0];
            last_r  <= in_tdata[11:6];
            red_r   <= in_tdata[19:12];
            green_r <= in_tdata[27:20];
            blue_r  <= in_tdata[35:28];
            level_r <= in_tdata[41:36];
            slot_r  <= in_tdata[49:42];
            entry_r <= in_tdata[57:50];
            st_r    <= S_DECODE;
          end
        end
        S_DECODE: begin
          read_ok_r <= (op_r == OP_READ) && first_ok;
          case (op_r)
            OP_SHOW: begin
              status_r <= ST_OK;
              st_r     <= S_SH_HDR;
            end
            OP_READ: begin
              status_r <= status_nxt;
              st_r     <= S_RESULT;
            end
            OP_SET_ALL, OP_SET_COLOUR, OP_SET_LEVEL, OP_CLEAR: begin
              status_r <= status_nxt;
              idx_r    <= first_r[IDX_W-1:0];
              st_r     <= (status_nxt == ST_OK) ? S_WR_RD : S_RESULT;
            end
            default: begin
              status_r <= ST_OK;
              st_r     <= S_RESULT;
            end
          endcase
        end
        S_WR_RD: begin
          st_r <= S_WR_WB;
        end
        S_WR_WB: begin
          idx_r <= idx_r + IDX_W'(1);
          st_r  <= idx_at_last ? S_RESULT : S_WR_RD;
        end
        S_RESULT: begin
          if (slot_free) begin
            st_r <= S_IDLE;
          end
        end
        S_SH_HDR: begin
          if (slot_free) begin
            idx_r <= '0;
            st_r  <= S_SH_RD;
          end
        end
        S_SH_RD: begin
          st_r <= S_SH_PIX;
        end
        S_SH_PIX: begin
          px_r <= pix_rdata;
          lv_r <= vbr_en ? vbr_level(pix_rdata) : pix_rdata.level;
          st_r <= gamma_en ? S_SH_G1 : S_SH_WORD;
        end
        S_SH_G1: begin
          gb_r <= gam_rdata;
          st_r <= S_SH_G2;
        end
        S_SH_G2: begin
          gg_r <= gam_rdata;
          st_r <= S_SH_G3;
        end
        S_SH_G3: begin
          gr_r <= gam_rdata;
          st_r <= S_SH_WORD;
        end
        S_SH_WORD: begin
          if (slot_free) begin
            idx_r <= idx_r + IDX_W'(1);
            st_r  <= idx_at_end ? S_SH_FTR : S_SH_RD;
          end
        end
        S_SH_FTR: begin
          if (slot_free) begin
            st_r <= S_IDLE;
          end
        end
        default: begin
          st_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_tready  = (st_r == S_IDLE);
  assign out_tvalid = out_tvalid_r;
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {out_pix_r.level, out_pix_r.blue, out_pix_r.green, out_pix_r.red,
                       out_bytes_r, out_word_r};

endmodule

/* hdl/apa102_strip_frame_engine_unit.sv */
// ----------------------------------------------------------------------------
// apa102_strip_frame_engine_unit
// Pixel store and APA102 frame encoder with range writes, read-back and show.
// ----------------------------------------------------------------------------
// Commands arrive as beats on the in_ channel (operation in in_tuser), and
// every command answers with beats on the out_ channel (status in out_tuser);
// the last beat of each answer carries out_tlast. Show answers with a header
// word, one word per LED and a footer; all other commands answer with one beat.
// Registers are written on the cfg_ channel, which is always ready. The user
// must write them only while no command is in flight; it is not enforced.
// One command is in flight at a time. The sequencer walks the pixel memory
// one LED at a time, and the gamma memory serves one lookup per cycle.
// After reset every LED is full brightness and black and the gamma table is
// the identity; both come from per-entry valid bits, so no clearing pass is
// needed. When the receiver stalls, the result register holds its beat and the
// sequencer waits; a new command is still taken while the last beat waits.
// ----------------------------------------------------------------------------
module apa102_strip_frame_engine_unit #(
  parameter int MAX_LEDS = asfe_pkg::MAX_LEDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // first_index, last_index, red_in, green_in, blue_in, level_in, gamma_slot,
  // gamma_entry, zero fill
  input  logic [63:0] in_tdata,
  // operation
  input  logic [2:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // stream_word, byte_count, red_out, green_out, blue_out, level_out
  output logic [63:0] out_tdata,
  // status
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [5:0]  cfg_data
);
  import asfe_pkg::*;

  localparam int IDX_W = (MAX_LEDS > 1) ? $clog2(MAX_LEDS) : 1;
  localparam int CNT_W = $clog2(MAX_LEDS + 1);

  logic [CNT_W-1:0] count_r, count_nxt;
  logic             gamma_en_r, vbr_en_r;
  logic             clr_en;

  pix_cmd_t         pix_cmd;
  logic [IDX_W-1:0] pix_addr;
  pix_t             pix_wdata, pix_rdata;
  gam_req_t         gam_req;
  logic [7:0]       gam_rdata;

  always_comb begin
    if (cfg_data == '0) begin
      count_nxt = CNT_W'(1);
    end else if (cfg_data > FIELD_IDX_W'(MAX_LEDS)) begin
      count_nxt = CNT_W'(MAX_LEDS);
    end else begin
      count_nxt = CNT_W'(cfg_data);
    end
  end

  assign clr_en = cfg_valid && (cfg_index == CFG_LED_COUNT) && (count_nxt > count_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r    <= CNT_W'(1);
      gamma_en_r <= 1'b0;
      vbr_en_r   <= 1'b0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_LED_COUNT: count_r    <= count_nxt;
        CFG_GAMMA_EN:  gamma_en_r <= cfg_data[0];
        CFG_VBR_EN:    vbr_en_r   <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  assign cfg_ready = 1'b1;

  asfe_pix_mem #(.MAX_LEDS(MAX_LEDS)) u_pix (
    .clk    (clk),
    .rst_n  (rst_n),
    .cmd    (pix_cmd),
    .addr   (pix_addr),
    .wdata  (pix_wdata),
    .clr_en (clr_en),
    .clr_lo (count_r),
    .clr_hi (count_nxt),
    .rdata  (pix_rdata)
  );

  asfe_gam_mem u_gam (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (gam_req),
    .rdata (gam_rdata)
  );

  asfe_seq #(.MAX_LEDS(MAX_LEDS)) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .count      (count_r),
    .gamma_en   (gamma_en_r),
    .vbr_en     (vbr_en_r),
    .pix_cmd    (pix_cmd),
    .pix_addr   (pix_addr),
    .pix_wdata  (pix_wdata),
    .pix_rdata  (pix_rdata),
    .gam_req    (gam_req),
    .gam_rdata  (gam_rdata)
  );

endmodule

/* hdl/asfe_checker.sv */
// ----------------------------------------------------------------------------
// asfe_checker
// Port-level checks of the strip frame engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "apa102_strip_frame_engine_unit_assert.svh"

module asfe_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata,
  input logic [1:0]  out_tuser,
  input logic        out_tlast
);
  import asfe_pkg::*;

  `ASFE_ASSERT_NXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "Stalled result beat changed.")

  `ASFE_ASSERT_NXT(a_one_cmd, clk, rst_n, in_tvalid && in_tready, !in_tready, "Second command taken while one is in flight.")

  `ASFE_ASSERT_IMP(a_word_bytes, clk, rst_n, out_tvalid && !out_tlast, out_tdata[34:32] == WORD_BYTES, "Stream word beat without four valid bytes.")

  `ASFE_ASSERT_IMP(a_err_single, clk, rst_n, out_tvalid && (out_tuser != ST_OK), out_tlast && (out_tdata[34:0] == 35'd0), "Error status on a stream beat.")

endmodule

bind apa102_strip_frame_engine_unit asfe_checker u_asfe_checker (.*);
